>>> sv/kti_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status types for the keyframe table interpolator.
package kti_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int CHANNEL_COUNT = 4;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int DEPTH  = CHANNEL_COUNT * TABLE_ENTRIES;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam int KEY_W     = 24;
   localparam int VAL_W     = 8;
   localparam int FRAC_W    = 16;
   localparam int RES_W     = 16;
   localparam int RAM_W     = KEY_W + VAL_W;
   localparam int DIV_CNT_W = $clog2(FRAC_W);
   localparam int PROD_W    = VAL_W + FRAC_W;

   localparam int YEAR_BASE_W = 15;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_YEAR_BASE = 1'b0;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ADDR_CUR,
      ADDR_NEXT,
      ADDR_FIRST
   } addr_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CH_START,
      OP_CUR_INC,
      OP_CUR_DEC,
      OP_CAP0,
      OP_CAP1,
      OP_DIV_SETUP,
      OP_DIV_STEP,
      OP_MUL,
      OP_ADD,
      OP_SINGLE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type       op;
      addr_sel_type addr_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_query;
      logic n_zero;
      logic n_one;
      logic cur_below_last;
      logic cur_above_zero;
      logic key_le_q;
      logic div_trivial;
      logic div_done;
      logic out_free;
      logic last_ch;
   } dp_status_type;

endpackage

>>> sv/kti_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the keyframe table interpolator.
interface kti_req_if;
   logic              valid;
   logic              ready;
   logic              action;
   logic [1:0]        channel;
   logic [7:0]        entry_index;
   logic [23:0]       entry_time;
   logic [7:0]        entry_value;
   logic signed [15:0] year;
   logic signed [7:0] month;
   logic signed [7:0] day;
   logic signed [7:0] hour;
   logic signed [7:0] minute;

   modport source (output valid, action, channel, entry_index, entry_time, entry_value,
                   year, month, day, hour, minute, input ready);
   modport sink (input valid, action, channel, entry_index, entry_time, entry_value,
                 year, month, day, hour, minute, output ready);
   modport monitor (input valid, ready, action, channel, entry_index, entry_time,
                    entry_value, year, month, day, hour, minute);
endinterface

interface kti_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_channel;
   logic [15:0] interp_value;
   logic [15:0] fraction;
   logic [3:0]  clamped_year;
   logic [3:0]  clamped_month;
   logic [4:0]  clamped_day;
   logic        last;

   modport source (output valid, out_channel, interp_value, fraction, clamped_year,
                   clamped_month, clamped_day, last, input ready);
   modport sink (input valid, out_channel, interp_value, fraction, clamped_year,
                 clamped_month, clamped_day, last, output ready);
endinterface

>>> sv/kti_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module kti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/kti_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: cursor walk, divide, multiply and result hand-off.
module kti_ctrl
   import kti_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          req_ready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CH_START,
      S_SINGLE_RD,
      S_SINGLE_CAP,
      S_FWD_TEST,
      S_FWD_RD,
      S_FWD_CHK,
      S_BACK_TEST,
      S_BACK_RD,
      S_BACK_CHK,
      S_K0_RD,
      S_K1_RD,
      S_K1_CAP,
      S_DIV_SETUP,
      S_DIV,
      S_MUL_ADD
   } state_type;

   state_type state_ff, state_in;
   logic      add_ff, add_in;
   logic      emit_ff, emit_in;

   always_comb begin
      state_in     = state_ff;
      add_in       = 1'b0;
      emit_in      = 1'b0;
      cmd.op       = OP_NONE;
      cmd.addr_sel = ADDR_CUR;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.op = OP_ACCEPT;
               if (status.req_query) begin
                  state_in = S_CH_START;
               end
            end
         end
         S_CH_START: begin
            cmd.op = OP_CH_START;
            priority if (status.n_zero) begin
               state_in = S_MUL_ADD;
               emit_in  = 1'b1;
            end else if (status.n_one) begin
               state_in = S_SINGLE_RD;
            end else begin
               state_in = S_FWD_TEST;
            end
         end
         S_SINGLE_RD: begin
            cmd.addr_sel = ADDR_FIRST;
            state_in     = S_SINGLE_CAP;
         end
         S_SINGLE_CAP: begin
            cmd.op   = OP_SINGLE;
            state_in = S_MUL_ADD;
            emit_in  = 1'b1;
         end
         S_FWD_TEST: begin
            state_in = status.cur_below_last ? S_FWD_RD : S_BACK_TEST;
         end
         S_FWD_RD: begin
            cmd.addr_sel = ADDR_NEXT;
            state_in     = S_FWD_CHK;
         end
         S_FWD_CHK: begin
            if (status.key_le_q) begin
               cmd.op   = OP_CUR_INC;
               state_in = S_FWD_TEST;
            end else begin
               state_in = S_BACK_TEST;
            end
         end
         S_BACK_TEST: begin
            state_in = status.cur_above_zero ? S_BACK_RD : S_K0_RD;
         end
         S_BACK_RD: begin
            cmd.addr_sel = ADDR_CUR;
            state_in     = S_BACK_CHK;
         end
         S_BACK_CHK: begin
            if (!status.key_le_q) begin
               cmd.op   = OP_CUR_DEC;
               state_in = S_BACK_TEST;
            end else begin
               state_in = S_K0_RD;
            end
         end
         S_K0_RD: begin
            cmd.addr_sel = ADDR_CUR;
            state_in     = S_K1_RD;
         end
         S_K1_RD: begin
            cmd.addr_sel = ADDR_NEXT;
            cmd.op       = OP_CAP0;
            state_in     = S_K1_CAP;
         end
         S_K1_CAP: begin
            cmd.op   = OP_CAP1;
            state_in = S_DIV_SETUP;
         end
         S_DIV_SETUP: begin
            cmd.op   = OP_DIV_SETUP;
            state_in = status.div_trivial ? S_MUL_ADD : S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_done) begin
               state_in = S_MUL_ADD;
            end
         end
         S_MUL_ADD: begin
            // Multiply, add, hand off; empty and one-entry tables only hand off.
            priority if (emit_ff) begin
               emit_in = 1'b1;
               if (status.out_free) begin
                  cmd.op  = OP_EMIT;
                  emit_in = 1'b0;
                  state_in = status.last_ch ? S_IDLE : S_CH_START;
               end
            end else if (add_ff) begin
               cmd.op  = OP_ADD;
               emit_in = 1'b1;
            end else begin
               cmd.op = OP_MUL;
               add_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         add_ff   <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         add_ff   <= add_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

>>> sv/kti_datapath.sv
`timescale 1ns / 1ps
// Datapath: clamp and key packing, tables, cursors, divider, multiplier, result register.
module kti_datapath
   import kti_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   kti_req_if.sink                req,
   kti_rsp_if.source              rsp,
   input  logic                   req_ready,
   input  logic [YEAR_BASE_W-1:0] year_base,
   input  dp_cmd_type             cmd,
   output dp_status_type          status
);

   // Query latched at acceptance.
   logic [KEY_W-1:0] q_ff;
   logic [3:0]       cy_ff;
   logic [3:0]       cm_ff;
   logic [4:0]       cd_ff;
   logic [CH_W-1:0]  ch_ff;
   logic [IDX_W-1:0] cur_ff;
   logic [IDX_W-1:0] cursor_ff [CHANNEL_COUNT];
   logic [CNT_W-1:0] count_ff [CHANNEL_COUNT];
   logic [KEY_W-1:0] k0_ff, k1_ff;
   logic [VAL_W-1:0] v0_ff, v1_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [KEY_W:0]    rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [RES_W-1:0]  val_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_channel_ff;
   logic [RES_W-1:0]  rsp_value_ff;
   logic [FRAC_W-1:0] rsp_frac_ff;
   logic [3:0]        rsp_year_ff;
   logic [3:0]        rsp_month_ff;
   logic [4:0]        rsp_day_ff;
   logic              rsp_last_ff;

   // Date clamping.
   logic [17:0] ydiff;
   logic [3:0]  cy;
   logic [3:0]  cm;
   logic [4:0]  cd;
   logic [4:0]  chr;
   logic [5:0]  cmi;

   assign req.ready = req_ready;

   always_comb begin
      ydiff = {{2{req.year[15]}}, req.year} - {3'b000, year_base};
      cy  = ydiff[3:0];
      cm  = req.month[3:0];
      cd  = req.day[4:0];
      chr = req.hour[4:0];
      cmi = req.minute[5:0];
      priority if (ydiff[17]) begin
         cy = 4'd0; cm = 4'd1; cd = 5'd1; chr = 5'd0; cmi = 6'd0;
      end else if (ydiff[16:4] != 13'd0) begin
         cy = 4'd15; cm = 4'd12; cd = 5'd31; chr = 5'd23; cmi = 6'd59;
      end else if (req.month[7] || req.month == 8'sd0) begin
         cm = 4'd1; cd = 5'd1; chr = 5'd0; cmi = 6'd0;
      end else if (req.month > 8'sd12) begin
         cm = 4'd12; cd = 5'd31; chr = 5'd23; cmi = 6'd59;
      end else if (req.day[7] || req.day == 8'sd0) begin
         cd = 5'd1; chr = 5'd0; cmi = 6'd0;
      end else if (req.day > 8'sd31) begin
         cd = 5'd31; chr = 5'd23; cmi = 6'd59;
      end else if (req.hour[7]) begin
         chr = 5'd0; cmi = 6'd0;
      end else if (req.hour > 8'sd23) begin
         chr = 5'd23; cmi = 6'd59;
      end else if (req.minute[7]) begin
         cmi = 6'd0;
      end else if (req.minute > 8'sd59) begin
         cmi = 6'd59;
      end
   end

   // Load decode.
   logic             load_ok;
   logic [IDX_W-1:0] load_idx;
   logic [CH_W-1:0]  load_ch;
   logic             ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [RAM_W-1:0]  ram_rdata;
   logic [IDX_W-1:0]  idx_sel;
   logic [IDX_W-1:0]  cur_next;

   assign load_ok  = (int'(req.channel) < CHANNEL_COUNT) &&
                     (int'(req.entry_index) < TABLE_ENTRIES);
   assign load_idx = IDX_W'(req.entry_index);
   assign load_ch  = CH_W'(req.channel);
   assign ram_we   = (cmd.op == OP_ACCEPT) && (req.action == ACTION_LOAD) && load_ok;
   assign ram_waddr = ADDR_W'(int'(load_ch) * TABLE_ENTRIES + int'(load_idx));
   assign cur_next = cur_ff + 1'b1;

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_NEXT:  idx_sel = cur_next;
         ADDR_FIRST: idx_sel = '0;
         default:    idx_sel = cur_ff;
      endcase
   end

   assign ram_raddr = ADDR_W'(int'(ch_ff) * TABLE_ENTRIES + int'(idx_sel));

   kti_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({req.entry_time, req.entry_value}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Cursor limits and division status.
   logic [CNT_W-1:0] n_cur;
   logic [CNT_W-1:0] last_idx;
   logic [CNT_W-1:0] cursor_ext;
   logic [KEY_W-1:0] num, den;
   logic             span_ok;
   logic [KEY_W:0]   rem_shift;
   logic             rem_ge;
   logic [VAL_W-1:0] vdiff;

   assign n_cur      = count_ff[ch_ff];
   assign last_idx   = n_cur - CNT_W'(2);
   assign cursor_ext = CNT_W'(cursor_ff[ch_ff]);
   assign num        = q_ff - k0_ff;
   assign den        = k1_ff - k0_ff;
   assign span_ok    = (q_ff > k0_ff) && (k1_ff > k0_ff);
   assign rem_shift  = {rem_ff[KEY_W-1:0], 1'b0};
   assign rem_ge     = rem_shift >= {1'b0, den};
   assign vdiff      = (v1_ff >= v0_ff) ? (v1_ff - v0_ff) : (v0_ff - v1_ff);

   assign status.req_valid      = req.valid;
   assign status.req_query      = (req.action == ACTION_QUERY);
   assign status.n_zero         = (n_cur == '0);
   assign status.n_one          = (n_cur == CNT_W'(1));
   assign status.cur_below_last = CNT_W'(cur_ff) < last_idx;
   assign status.cur_above_zero = (cur_ff != '0);
   assign status.key_le_q       = ram_rdata[RAM_W-1:VAL_W] <= q_ff;
   assign status.div_trivial    = !span_ok || (num >= den);
   assign status.div_done       = (div_cnt_ff == DIV_CNT_W'(FRAC_W - 1));
   assign status.out_free       = !rsp_valid_ff || rsp.ready;
   assign status.last_ch        = (ch_ff == CH_W'(CHANNEL_COUNT - 1));

   // Control state: counts, cursors, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            count_ff[i]  <= '0;
            cursor_ff[i] <= '0;
         end
      end else begin
         if (ram_we && (CNT_W'(load_idx) + CNT_W'(1) > count_ff[load_ch])) begin
            count_ff[load_ch] <= CNT_W'(load_idx) + CNT_W'(1);
         end
         if (cmd.op == OP_CAP0) begin
            cursor_ff[ch_ff] <= cur_ff;
         end
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ACCEPT: begin
            q_ff  <= {cy, cm, cd, chr, cmi};
            cy_ff <= cy;
            cm_ff <= cm;
            cd_ff <= cd;
            ch_ff <= '0;
         end
         OP_CH_START: begin
            cur_ff  <= (cursor_ext > last_idx) ? IDX_W'(last_idx) : cursor_ff[ch_ff];
            val_ff  <= '0;
            frac_ff <= '0;
         end
         OP_CUR_INC: cur_ff <= cur_next;
         OP_CUR_DEC: cur_ff <= cur_ff - 1'b1;
         OP_CAP0: begin
            k0_ff <= ram_rdata[RAM_W-1:VAL_W];
            v0_ff <= ram_rdata[VAL_W-1:0];
         end
         OP_CAP1: begin
            k1_ff <= ram_rdata[RAM_W-1:VAL_W];
            v1_ff <= ram_rdata[VAL_W-1:0];
         end
         OP_DIV_SETUP: begin
            // A key at or past the upper key saturates; a flat or empty span gives zero.
            frac_ff    <= span_ok ? {FRAC_W{1'b1}} : '0;
            rem_ff     <= {1'b0, num};
            div_cnt_ff <= '0;
         end
         OP_DIV_STEP: begin
            rem_ff     <= rem_ge ? (rem_shift - {1'b0, den}) : rem_shift;
            frac_ff    <= {frac_ff[FRAC_W-2:0], rem_ge};
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         OP_MUL: prod_ff <= vdiff * frac_ff;
         OP_ADD: begin
            if (v1_ff >= v0_ff) begin
               val_ff <= {v0_ff, 8'd0} + prod_ff[PROD_W-1:8];
            end else begin
               val_ff <= {v0_ff, 8'd0} - prod_ff[PROD_W-1:8];
            end
         end
         OP_SINGLE: begin
            val_ff  <= {ram_rdata[VAL_W-1:0], 8'd0};
            frac_ff <= '0;
         end
         OP_EMIT: begin
            rsp_channel_ff <= 2'(ch_ff);
            rsp_value_ff   <= val_ff;
            rsp_frac_ff    <= frac_ff;
            rsp_year_ff    <= cy_ff;
            rsp_month_ff   <= cm_ff;
            rsp_day_ff     <= cd_ff;
            rsp_last_ff    <= status.last_ch;
            ch_ff          <= ch_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_channel   = rsp_channel_ff;
   assign rsp.interp_value  = rsp_value_ff;
   assign rsp.fraction      = rsp_frac_ff;
   assign rsp.clamped_year  = rsp_year_ff;
   assign rsp.clamped_month = rsp_month_ff;
   assign rsp.clamped_day   = rsp_day_ff;
   assign rsp.last          = rsp_last_ff;

endmodule

>>> sv/keyframe_table_interpolator_unit.sv
`timescale 1ns / 1ps
// Top level of the keyframe table interpolator: APB register, controller and datapath.
//
//   Channel   Direction   Handshake              Moves
//   req       in          valid / ready          load or query request
//   rsp       out         valid / ready          one result per table on a query
//   APB       in          psel/penable/pready    year_base register
//
// A load request is written from idle, which stays ready for the next one. A query gives
// one result per table, in table order. When no bound check reads a key, a table with two
// or more entries steps through start, two tests, two reads, capture, setup, 16-step
// divide, multiply, add and hand-off; a failing bound check and each cursor step add a key
// read on the one read port. A trivial span skips the divide, an empty table the whole walk.
// Reset is synchronous and clears all counts and cursors; the table RAM is not cleared.
// A stalled result holds the controller in its hand-off step; a new request is taken
// once the last result of a query sits in the output register.
module keyframe_table_interpolator_unit
   import kti_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   kti_req_if.sink               req,
   kti_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // The year base is the only register; byte lanes within the word are ignored.
   logic [YEAR_BASE_W-1:0] year_base_ff;
   logic                   csr_hit;

   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_YEAR_BASE);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? CSR_DATA_W'(year_base_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_base_ff <= '0;
      end else if (psel && penable && pwrite && csr_hit) begin
         year_base_ff <= pwdata[YEAR_BASE_W-1:0];
      end
   end

   // The controller sequences each request; the datapath holds all tables and arithmetic.
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ctrl_ready;

   kti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (ctrl_ready)
   );

   kti_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .req_ready (ctrl_ready),
      .year_base (year_base_ff),
      .cmd       (cmd),
      .status    (status)
   );

`ifndef NO_ASSERTIONS
   // The last flag marks exactly the final table's result.
   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.last == (rsp.out_channel == 2'(CHANNEL_COUNT - 1))))
      else $error("last flag does not match channel");

   // Clamped month always lies in 1..12.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.clamped_month >= 4'd1 && rsp.clamped_month <= 4'd12))
      else $error("clamped month out of range");

   // Clamped day is never zero.
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.clamped_day != 5'd0))
      else $error("clamped day out of range");

   // A result is only started when the output register is free.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> (!rsp.valid || rsp.ready))
      else $error("result overwritten while stalled");
`endif

endmodule
